[src/thc_pkg.sv]
// Shared types and constants for the thermal core hotplug hysteresis block.
// No dependencies; every other file imports this package.
package thc_pkg;

  // Mask and index field widths are derived from the core count
  localparam int NUM_CORES  = 4;
  localparam int CORE_IDX_W = $clog2(NUM_CORES);
  localparam int TEMP_W     = 9;
  localparam int HYST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Request codes on the result beat
  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_DOWN = 2'd1,
    REQ_UP   = 2'd2
  } req_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_CORE_MASK  = 2'd1,
    CFG_LIMIT_TEMP = 2'd2,
    CFG_HYSTERESIS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                     enable;
    logic [NUM_CORES-1:0]     core_mask;
    logic signed [TEMP_W-1:0] limit_temp;
    logic [HYST_W-1:0]        hysteresis;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [NUM_CORES-1:0]     online_cores;
  } in_item_t;

  typedef struct packed {
    req_t                  request;
    logic [CORE_IDX_W-1:0] core_index;
    logic [NUM_CORES-1:0]  held_offline;
  } out_item_t;

endpackage

[src/thc_cfg_regs.sv]
// Configuration register file for the thermal core hotplug block.
// Depends on thc_pkg for the register index codes and cfg_t.
module thc_cfg_regs import thc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Address decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:     cfg_nxt.enable     = cfg_wdata[0];
        CFG_CORE_MASK:  cfg_nxt.core_mask  = cfg_wdata[NUM_CORES-1:0];
        CFG_LIMIT_TEMP: cfg_nxt.limit_temp = $signed(cfg_wdata[TEMP_W-1:0]);
        CFG_HYSTERESIS: cfg_nxt.hysteresis = cfg_wdata[HYST_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/thc_decide.sv]
// Combinational decision logic: threshold compares and the two core scans.
// Depends on thc_pkg for cfg_t, in_item_t, out_item_t and request codes.
module thc_decide import thc_pkg::*; (
  input  cfg_t                 cfg,
  input  logic [NUM_CORES-1:0] held,
  input  in_item_t             item,
  output out_item_t            result
);

  logic signed [TEMP_W:0]    low_thr;
  logic                      hot;
  logic                      cool;
  logic                      dn_found;
  logic [CORE_IDX_W-1:0]     dn_idx;
  logic                      up_found;
  logic [CORE_IDX_W-1:0]     up_idx;
  logic [NUM_CORES-1:0]      up_clr;

  // Thresholds; release level kept one bit wider so it cannot wrap
  always_comb begin
    low_thr = $signed({item.temp[TEMP_W-1], item.temp}) ;
    low_thr = $signed({cfg.limit_temp[TEMP_W-1], cfg.limit_temp})
            - $signed({2'b00, cfg.hysteresis});
    hot  = $signed(item.temp) >= $signed(cfg.limit_temp);
    cool = $signed({item.temp[TEMP_W-1], item.temp}) <= low_thr;
  end

  // Down scan: highest allowed core above core 0 not already held and offline
  always_comb begin
    dn_found = 1'b0;
    dn_idx   = '0;
    for (int i = NUM_CORES - 1; i > 0; i--) begin
      if (!dn_found && cfg.core_mask[i] && !(held[i] && !item.online_cores[i])) begin
        dn_found = 1'b1;
        dn_idx   = i[CORE_IDX_W-1:0];
      end
    end
  end

  // Up scan: release held cores from core 0 up to and including the first held one that is offline
  always_comb begin
    up_found = 1'b0;
    up_idx   = '0;
    up_clr   = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (!up_found && held[i]) begin
        up_clr[i] = 1'b1;
        if (!item.online_cores[i]) begin
          up_found = 1'b1;
          up_idx   = i[CORE_IDX_W-1:0];
        end
      end
    end
  end

  // Pick the action
  always_comb begin
    result.request      = REQ_NONE;
    result.core_index   = '0;
    result.held_offline = held;
    if (cfg.enable && (cfg.core_mask != '0)) begin
      if (hot) begin
        if (dn_found) begin
          result.request          = REQ_DOWN;
          result.core_index       = dn_idx;
          result.held_offline     = held;
          result.held_offline[dn_idx] = 1'b1;
        end
      end else if ((held != '0) && cool) begin
        result.held_offline = held & ~up_clr;
        if (up_found) begin
          result.request    = REQ_UP;
          result.core_index = up_idx;
        end
      end
    end
  end

endmodule

[src/thermal_core_hotplug_hysteresis.sv]
// Top level of the thermal core hotplug hysteresis block.
// Depends on thc_pkg, thc_cfg_regs and thc_decide.
//
// One beat in gives exactly one beat out. A reading is captured in an input
// register, decided against the held-offline mask once the output register
// is free and written to it; the mask is updated in the same cycle.
// Sustained rate is one beat per cycle while the output is not stalled,
// set by the single input-to-output register pair; when the output is
// stalled the input register still takes one more beat. Configuration is
// written through cfg_we/cfg_index/cfg_wdata and must only change while
// no beat is in flight.
module thermal_core_hotplug_hysteresis import thc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                 cfg;
  logic                 in_valid_r;
  in_item_t             in_data_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic [NUM_CORES-1:0] held_r;
  out_item_t            result;
  logic                 advance;

  thc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  thc_decide u_decide (
    .cfg    (cfg),
    .held   (held_r),
    .item   (in_data_r),
    .result (result)
  );

  // Move the captured beat into the output register when it is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Valid flags and the held mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        held_r      <= result.held_offline;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/thc_checker.sv]
// Port-level checker for the thermal core hotplug block, bound to the top.
// Depends on thc_pkg for the result beat type and request codes.
module thc_checker import thc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // No request means index zero
  a_none_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.request == REQ_NONE |-> out_data.core_index == '0)
    else $error("core_index nonzero without a request");

  // A down request never targets core 0 and leaves the core held
  a_down_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.request == REQ_DOWN |->
      out_data.core_index != '0 && out_data.held_offline[out_data.core_index])
    else $error("down request not reflected in held mask");

  // An up request has released the core it names
  a_up_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.request == REQ_UP |->
      !out_data.held_offline[out_data.core_index])
    else $error("up request for a core still held");

endmodule

bind thermal_core_hotplug_hysteresis thc_checker u_thc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
